### hdl/dlsu_pkg.sv
// Shared types and constants for the delayed leaky synapse update block.
package dlsu_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_TAU      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EFFICACY       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEPS    = 2'd3;

	localparam logic [31:0] FIRE_THRESHOLD_RST = 32'd0;
	localparam logic [16:0] RECIP_TAU_RST      = 17'd65536;
	localparam logic [24:0] EFFICACY_RST       = 25'd65536;
	localparam logic [6:0]  DELAY_STEPS_RST    = 7'd1;

	// sqrt(0.5) in unsigned Q0.16
	localparam logic [15:0] SQRT_HALF_Q16 = 16'd46341;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] presyn_drive;
		logic signed [31:0] presyn_noise;
	} in_t;

	typedef struct packed {
		logic signed [31:0] delayed_current;
		logic signed [31:0] weighted_contribution;
		logic signed [31:0] current_now;
	} out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_TERM,
		ST_TMUL,
		ST_SUM,
		ST_WB
	} state_t;

	typedef struct packed {
		logic clear_we;
		logic accept;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

endpackage

### hdl/delayed_leaky_synapse_update.sv
// Top level of the delayed leaky synapse update block.
//
// One input item is one 0.5 ms time step of one synapse: presynaptic drive
// and noise. Each item yields exactly one result item: the value popped from
// the delay ring, that value times efficacy, and the updated current.
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data, with
// an item moving when valid and ready are both high. cfg_we/cfg_idx/cfg_wdata
// write one config register per cycle; write only while idle.
// Items are worked one at a time: in_ready rises at the same edge that loads
// the result, so a new item is taken only after the last one is written back.
// Each item passes ring read, activation and products, update term, two
// partial products, partial-product sum and write-back, in that order.
// A finished result sits in the output register; the next item is accepted
// and computed meanwhile, and only its write-back waits while out_ready is
// low, holding the ring and current unchanged until the result can load.
// Reset: registers take their reset values and the ring memory is swept to
// zero, one entry a cycle, over all MAX_DELAY entries, with in_ready low.
module delayed_leaky_synapse_update #(
	parameter int MAX_DELAY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dlsu_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dlsu_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [dlsu_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dlsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	dlsu_pkg::cmd_t   cmd;
	dlsu_pkg::sts_t   sts;
	dlsu_pkg::state_t state;

	dlsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	dlsu_dp #(
		.MAX_DELAY (MAX_DELAY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// an accepted item blocks the input until its write-back
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice without write-back");

	// write-back only into a free output register
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result overwritten before taken");

	// no item taken during the ring clear sweep
	a_clear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state == dlsu_pkg::ST_CLEAR) |-> (!in_ready && !cmd.commit))
		else $error("activity during ring clear");

	// every commit produces a valid result next cycle
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit without result");

endmodule

### hdl/dlsu_ctrl.sv
// Sequencer for one synapse step: ring clear, accept, arithmetic steps, write-back.
module dlsu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dlsu_pkg::sts_t   sts,
	output dlsu_pkg::cmd_t   cmd,
	output dlsu_pkg::state_t state
);

	dlsu_pkg::state_t state_q;
	dlsu_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlsu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlsu_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_d = dlsu_pkg::ST_IDLE;
			end
			dlsu_pkg::ST_IDLE: begin
				if (in_valid) state_d = dlsu_pkg::ST_MUL;
			end
			dlsu_pkg::ST_MUL:  state_d = dlsu_pkg::ST_TERM;
			dlsu_pkg::ST_TERM: state_d = dlsu_pkg::ST_TMUL;
			dlsu_pkg::ST_TMUL: state_d = dlsu_pkg::ST_SUM;
			dlsu_pkg::ST_SUM:  state_d = dlsu_pkg::ST_WB;
			dlsu_pkg::ST_WB: begin
				if (out_free) state_d = dlsu_pkg::ST_IDLE;
			end
			default: state_d = dlsu_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dlsu_pkg::ST_CLEAR: cmd.clear_we = 1'b1;
			dlsu_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			dlsu_pkg::ST_MUL:  cmd.ld_s2 = 1'b1;
			dlsu_pkg::ST_TERM: cmd.ld_s3 = 1'b1;
			dlsu_pkg::ST_TMUL: cmd.ld_s4 = 1'b1;
			dlsu_pkg::ST_SUM:  cmd.ld_s5 = 1'b1;
			dlsu_pkg::ST_WB:   cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	// result register: loaded on commit, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

### hdl/dlsu_dp.sv
// Datapath: config registers, delay ring memory, current update arithmetic.
module dlsu_dp #(
	parameter int MAX_DELAY = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dlsu_pkg::cmd_t                      cmd,
	output dlsu_pkg::sts_t                      sts,
	input  dlsu_pkg::in_t                       in_data,
	output dlsu_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [dlsu_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dlsu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int DW0 = $clog2(MAX_DELAY + 1);
	localparam int DW  = (DW0 > 7) ? DW0 : 7;

	// configuration
	logic signed [31:0] thr_q;
	logic [16:0]        recip_tau_q;
	logic signed [24:0] eff_q;
	logic [6:0]         delay_steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= dlsu_pkg::FIRE_THRESHOLD_RST;
			recip_tau_q   <= dlsu_pkg::RECIP_TAU_RST;
			eff_q         <= dlsu_pkg::EFFICACY_RST;
			delay_steps_q <= dlsu_pkg::DELAY_STEPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dlsu_pkg::REG_FIRE_THRESHOLD: thr_q         <= cfg_wdata[31:0];
				dlsu_pkg::REG_RECIP_TAU:      recip_tau_q   <= cfg_wdata[16:0];
				dlsu_pkg::REG_EFFICACY:       eff_q         <= cfg_wdata[24:0];
				dlsu_pkg::REG_DELAY_STEPS:    delay_steps_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// effective delay length, clamped to 1..MAX_DELAY
	logic [DW-1:0] ds_ext;
	logic [DW-1:0] d_eff;
	always_comb begin
		ds_ext = DW'(delay_steps_q);
		if (ds_ext == '0) begin
			d_eff = DW'(1);
		end else if (ds_ext > DW'(MAX_DELAY)) begin
			d_eff = DW'(MAX_DELAY);
		end else begin
			d_eff = ds_ext;
		end
	end

	// ring head and clear sweep
	logic [AW-1:0] head_q;
	logic [AW-1:0] h_cur;
	logic [AW-1:0] h_q;
	logic [AW-1:0] h_next;
	logic [DW-1:0] h_inc;
	logic [AW-1:0] clr_q;

	assign h_cur  = (DW'(head_q) >= d_eff) ? '0 : head_q;
	assign h_inc  = DW'(h_q) + DW'(1);
	assign h_next = (h_inc >= d_eff) ? '0 : h_inc[AW-1:0];
	assign sts.clear_last = (clr_q == AW'(MAX_DELAY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_we) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// current state
	logic signed [31:0] m_q;
	logic signed [31:0] m_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= '0;
			head_q <= '0;
		end else if (cmd.commit) begin
			m_q    <= m_new;
			head_q <= h_next;
		end
	end

	// delay ring memory
	logic [31:0]        ring_mem [MAX_DELAY];
	logic signed [31:0] rd_s1;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [31:0]        mem_wd;

	assign mem_we = cmd.clear_we || cmd.commit;
	assign mem_wa = cmd.clear_we ? clr_q : h_q;
	assign mem_wd = cmd.clear_we ? '0 : m_new;

	always_ff @(posedge clk) begin
		if (mem_we) ring_mem[mem_wa] <= mem_wd;
		if (cmd.accept) rd_s1 <= ring_mem[h_cur];
	end

	// input capture
	logic signed [31:0] drive_q;
	logic signed [31:0] noise_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			drive_q <= in_data.presyn_drive;
			noise_q <= in_data.presyn_noise;
			h_q     <= h_cur;
		end
	end

	// stage 2: activation, products
	logic signed [32:0] sum_c;
	logic               fire_c;
	logic signed [32:0] act_c;
	logic signed [31:0] pass_c;
	logic signed [33:0] diff_s2;
	logic signed [48:0] np_s2;
	logic signed [56:0] wp_s2;

	assign sum_c  = 33'(drive_q) + 33'(noise_q);
	assign fire_c = !(sum_c < 33'(thr_q));
	assign act_c  = fire_c ? (33'(drive_q) - 33'(thr_q)) : '0;
	assign pass_c = fire_c ? noise_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.ld_s2) begin
			diff_s2 <= 34'(act_c) - 34'(m_q);
			np_s2   <= pass_c * $signed({1'b0, dlsu_pkg::SQRT_HALF_Q16});
			wp_s2   <= eff_q * rd_s1;
		end
	end

	// stage 3: Q.24 update term, weighted output with round and saturate
	logic signed [48:0] np_rnd;
	logic signed [41:0] term_c;
	logic signed [40:0] wr_c;
	logic signed [41:0] term_s3;
	logic signed [31:0] weighted_s3;

	assign np_rnd = (np_s2 + 49'sd128) >>> 8;
	assign term_c = (42'(diff_s2) <<< 7) + 42'(np_rnd);
	assign wr_c   = 41'((wp_s2 + 57'sd32768) >>> 16);

	always_ff @(posedge clk) begin
		if (cmd.ld_s3) begin
			term_s3 <= term_c;
			if (wr_c[40:31] == '0 || wr_c[40:31] == '1) begin
				weighted_s3 <= wr_c[31:0];
			end else begin
				weighted_s3 <= wr_c[40] ? dlsu_pkg::SAT_MIN : dlsu_pkg::SAT_MAX;
			end
		end
	end

	// stage 4: term * recip_tau as two partial products
	logic signed [17:0] rt_c;
	logic signed [21:0] tl_c;
	logic signed [20:0] th_c;
	logic signed [39:0] pl_s4;
	logic signed [38:0] ph_s4;

	assign rt_c = $signed({1'b0, recip_tau_q});
	assign tl_c = $signed({1'b0, term_s3[20:0]});
	assign th_c = term_s3[41:21];

	always_ff @(posedge clk) begin
		if (cmd.ld_s4) begin
			pl_s4 <= tl_c * rt_c;
			ph_s4 <= th_c * rt_c;
		end
	end

	// stage 5: combine partials, round to Q16.16
	logic signed [59:0] full_c;
	logic signed [35:0] delta_s5;

	assign full_c = (60'(ph_s4) <<< 21) + 60'(pl_s4) + 60'sd8388608;

	always_ff @(posedge clk) begin
		if (cmd.ld_s5) delta_s5 <= 36'(full_c >>> 24);
	end

	// write-back: saturated new current
	logic signed [36:0] msum_c;

	assign msum_c = 37'(m_q) + 37'(delta_s5);

	always_comb begin
		if (msum_c[36:31] == '0 || msum_c[36:31] == '1) begin
			m_new = msum_c[31:0];
		end else begin
			m_new = msum_c[36] ? dlsu_pkg::SAT_MIN : dlsu_pkg::SAT_MAX;
		end
	end

	dlsu_pkg::out_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.delayed_current       <= rd_s1;
			out_q.weighted_contribution <= weighted_s3;
			out_q.current_now           <= m_new;
		end
	end

	assign out_data = out_q;

endmodule

### dv/delayed_leaky_synapse_update_tb.sv
// Self-checking testbench for delayed_leaky_synapse_update: synapse step predictor plus scoreboard.
module delayed_leaky_synapse_update_tb;

	localparam int          RING_DEPTH  = 64;
	localparam int          CYCLE_LIMIT = 600000;
	localparam logic [31:0] Q_ONE       = 32'h0001_0000;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	dlsu_pkg::in_t                   in_data   = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	dlsu_pkg::out_t                  out_data;
	logic                            cfg_we    = 1'b0;
	logic [dlsu_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [dlsu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor copy of the registers and synapse state
	logic [31:0] thr_cfg;
	logic [16:0] rtau_cfg;
	logic [24:0] eff_cfg;
	logic [6:0]  delay_cfg;
	longint      syn_m;
	logic [31:0] ring_mem [RING_DEPTH];
	int          ring_pos;

	dlsu_pkg::out_t expected_steps [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int err_count      = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int cycle_count    = 0;

	delayed_leaky_synapse_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// One 0.5 ms step: pop the delayed current, then leaky update in Q.24 and push.
	function automatic dlsu_pkg::out_t predict_synapse_step(dlsu_pkg::in_t it);
		longint         drive, noise, thr, eff, rt, sqrt_half;
		longint         act, pass, popped, term, delta;
		int             len, pos;
		dlsu_pkg::out_t res;
		drive     = $signed(it.presyn_drive);
		noise     = $signed(it.presyn_noise);
		thr       = $signed(thr_cfg);
		eff       = $signed(eff_cfg);
		rt        = rtau_cfg;
		sqrt_half = dlsu_pkg::SQRT_HALF_Q16;
		len = delay_cfg;
		if (len == 0)
			len = 1;
		else if (len > RING_DEPTH)
			len = RING_DEPTH;
		// a shortened ring restarts at its first entry
		pos = (ring_pos >= len) ? 0 : ring_pos;

		popped = $signed(ring_mem[pos]);
		res.delayed_current       = ring_mem[pos];
		res.weighted_contribution = 32'(sat32((eff * popped + 32768) >>> 16));

		if (drive + noise < thr) begin
			act  = 0;
			pass = 0;
		end else begin
			act  = drive - thr;
			pass = noise;
		end
		term  = (act - syn_m) * 128 + ((pass * sqrt_half + 128) >>> 8);
		delta = (term * rt + 64'sd8388608) >>> 24;
		syn_m = sat32(syn_m + delta);

		ring_mem[pos] = 32'(syn_m);
		pos++;
		if (pos >= len)
			pos = 0;
		ring_pos = pos;
		res.current_now = 32'(syn_m);
		return res;
	endfunction

	task automatic model_reset();
		thr_cfg   = dlsu_pkg::FIRE_THRESHOLD_RST;
		rtau_cfg  = dlsu_pkg::RECIP_TAU_RST;
		eff_cfg   = dlsu_pkg::EFFICACY_RST;
		delay_cfg = dlsu_pkg::DELAY_STEPS_RST;
		syn_m     = 0;
		ring_pos  = 0;
		foreach (ring_mem[i])
			ring_mem[i] = '0;
	endtask

	function automatic logic [31:0] rand_q();
		logic [31:0] r;
		logic [31:0] corner [6];
		r = $urandom();
		corner = '{dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MIN, 32'd0, 32'hFFFF_FFFF, 32'd1, Q_ONE};
		case ($urandom_range(9))
			0, 1: return r;
			2: return corner[$urandom_range(5)];
			// within about +-32.0, where the current actually moves around
			default: return {{10{r[21]}}, r[21:0]};
		endcase
	endfunction

	task automatic cfg_write(logic [dlsu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			dlsu_pkg::REG_FIRE_THRESHOLD: thr_cfg   = value;
			dlsu_pkg::REG_RECIP_TAU:      rtau_cfg  = value[16:0];
			dlsu_pkg::REG_EFFICACY:       eff_cfg   = value[24:0];
			dlsu_pkg::REG_DELAY_STEPS:    delay_cfg = value[6:0];
			default: ;
		endcase
	endtask

	// upper bits of narrow registers carry junk; the block must drop them
	task automatic randomize_config();
		logic [31:0] junk;
		logic [16:0] rt;
		logic [24:0] ef;
		logic [6:0]  dl;
		junk = $urandom();
		case ($urandom_range(7))
			0:       rt = '0;
			1:       rt = 17'($urandom_range(65537, 131071));
			2:       rt = 17'($urandom());
			default: rt = 17'($urandom_range(1, 65536));
		endcase
		case ($urandom_range(5))
			0:       ef = 25'($urandom());
			default: ef = 25'($urandom_range(0, 16777216) - 8388608);
		endcase
		case ($urandom_range(7))
			0:       dl = '0;
			1:       dl = 7'($urandom_range(65, 127));
			2, 3:    dl = 7'($urandom_range(17, 64));
			default: dl = 7'($urandom_range(1, 16));
		endcase
		cfg_write(dlsu_pkg::REG_FIRE_THRESHOLD, rand_q());
		cfg_write(dlsu_pkg::REG_RECIP_TAU, {junk[31:17], rt});
		cfg_write(dlsu_pkg::REG_EFFICACY, {junk[31:25], ef});
		cfg_write(dlsu_pkg::REG_DELAY_STEPS, {junk[31:7], dl});
	endtask

	task automatic send_step(logic [31:0] drive, logic [31:0] noise);
		dlsu_pkg::in_t it;
		it.presyn_drive = drive;
		it.presyn_noise = noise;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		expected_steps.push_back(predict_synapse_step(it));
		items_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// sender idle until every expected result is back, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_steps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (err_count < 20)
			$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req > 0) begin
			out_ready <= 1'b0;
			hold_req  <= hold_req - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		dlsu_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_steps.size() == 0) begin
				report_mismatch("unexpected item, current_now", out_data.current_now, '0);
			end else begin
				want = expected_steps.pop_front();
				if (out_data.delayed_current !== want.delayed_current)
					report_mismatch("delayed_current", out_data.delayed_current,
						want.delayed_current);
				if (out_data.weighted_contribution !== want.weighted_contribution)
					report_mismatch("weighted_contribution", out_data.weighted_contribution,
						want.weighted_contribution);
				if (out_data.current_now !== want.current_now)
					report_mismatch("current_now", out_data.current_now, want.current_now);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_steps.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_directed_extremes();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// reset settings: threshold 0, unity rate and weight, one-step delay
		send_step('0, '0);                                   // sum exactly at threshold
		send_step(Q_ONE, '0);
		send_step('1, '0);                                   // just below threshold
		send_step(dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MIN);     // sum is -1, inactive
		send_step(dlsu_pkg::SAT_MIN, dlsu_pkg::SAT_MIN);
		send_step(32'd1, '1);                                // at threshold, noise passes
		send_step('0, Q_ONE);
		send_step(dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MAX);
		drain_results();
		// rate just under two, largest weight, delay of zero acts as one
		cfg_write(dlsu_pkg::REG_FIRE_THRESHOLD, dlsu_pkg::SAT_MIN);
		cfg_write(dlsu_pkg::REG_RECIP_TAU, 32'h0001_FFFF);
		cfg_write(dlsu_pkg::REG_EFFICACY, 32'h00FF_FFFF);
		cfg_write(dlsu_pkg::REG_DELAY_STEPS, '0);
		send_step(dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MAX);     // current saturates high
		send_step(dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MAX);     // weighted saturates high
		drain_results();
		// most negative weight on a saturated current; delay beyond the ring clamps
		cfg_write(dlsu_pkg::REG_EFFICACY, 32'h0100_0000);
		cfg_write(dlsu_pkg::REG_DELAY_STEPS, 32'd127);
		send_step(dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MAX);
		send_step(dlsu_pkg::SAT_MIN, '0);                    // active, zero activity, decays
		drain_results();
		// zero rate freezes the current
		cfg_write(dlsu_pkg::REG_RECIP_TAU, '0);
		send_step(dlsu_pkg::SAT_MAX, dlsu_pkg::SAT_MAX);
		send_step(dlsu_pkg::SAT_MIN, dlsu_pkg::SAT_MAX);
		drain_results();
		cfg_write(dlsu_pkg::REG_RECIP_TAU, 32'd1);
		cfg_write(dlsu_pkg::REG_FIRE_THRESHOLD, dlsu_pkg::SAT_MAX);
		send_step(dlsu_pkg::SAT_MAX, '0);                    // at the top threshold
		send_step(32'h7FFF_FFFE, '0);
		send_step(dlsu_pkg::SAT_MIN, dlsu_pkg::SAT_MIN);
		drain_results();
	endtask

	// ring lengths changed between runs; a shorter ring forces a head restart
	task automatic test_delay_lengths();
		int lens [6];
		lens = '{8, 3, 64, 1, 65, 17};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cfg_write(dlsu_pkg::REG_FIRE_THRESHOLD, '0);
		cfg_write(dlsu_pkg::REG_RECIP_TAU, 32'h0000_4000);
		cfg_write(dlsu_pkg::REG_EFFICACY, Q_ONE);
		foreach (lens[i]) begin
			cfg_write(dlsu_pkg::REG_DELAY_STEPS, lens[i]);
			repeat (lens[i] + 5) send_step(rand_q(), rand_q());
			drain_results();
		end
	endtask

	task automatic test_random_traffic();
		int pct_send [4];
		int pct_recv [4];
		pct_send = '{0, 87, 0, 36};
		pct_recv = '{0, 0, 87, 36};
		for (int p = 0; p < 4; p++) begin
			randomize_config();
			send_idle_pct  = pct_send[p];
			recv_stall_pct = pct_recv[p];
			for (int k = 0; k < 200; k++) begin
				if (k == 100) begin
					drain_results();
					randomize_config();
				end
				send_step(rand_q(), rand_q());
			end
			drain_results();
		end
	endtask

	// long output hold while the sender keeps offering, so the input stalls
	task automatic test_output_backpressure();
		randomize_config();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 300;
		repeat (40) send_step(rand_q(), rand_q());
		drain_results();
	endtask

	task automatic test_sender_pause();
		send_idle_pct  = 36;
		recv_stall_pct = 36;
		repeat (3) begin
			repeat (20) send_step(rand_q(), rand_q());
			drain_results();
		end
	endtask

	initial begin
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// the block sweeps its ring after reset with in_ready low
		do @(posedge clk); while (!in_ready);
		test_directed_extremes();
		test_delay_lengths();
		test_random_traffic();
		test_output_backpressure();
		test_sender_pause();
		$display("%0d synapse steps sent, %0d results checked: threshold and saturation corners,",
			items_sent, results_seen);
		$display("delay lengths 0..127, zero and above-one rates, idle/stall mixes, long hold");
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
